// ===== rtl/bit_pkg.sv =====
// ----------------------------------------------------------------------------
// bit_pkg
// Shared constants, types and helpers of the backtrace intern table.
// ----------------------------------------------------------------------------
package bit_pkg;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int MAX_DEPTH_DEF   = 16;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int ROT_RIGHT       = 3;
    localparam int ROT_LEFT        = 29;
    localparam int ID_W            = 10;
    localparam logic [4:0] DEPTH_RESET = 5'd4;

    typedef enum logic [1:0] {
        OUT_FOUND = 2'd0,
        OUT_NEW   = 2'd1,
        OUT_FULL  = 2'd2
    } t_outcome;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_GATHER,
        ST_HEAD,
        ST_HEAD_WAIT,
        ST_CHECK,
        ST_CMP,
        ST_CMP_WAIT,
        ST_LINK,
        ST_LINK_WAIT,
        ST_STORE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;  // empty one bucket head after reset
        logic head_rd;   // read bucket head
        logic cmp_start; // clear compare index, read first word
        logic cmp_step;  // compare word, advance
        logic link_rd;   // follow chain link
        logic store_step;// write one entry word
        logic store_fin; // link entry, bump pool count
        logic res_found;
        logic res_new;
        logic res_full;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;  // clearing pass at last bucket
        logic run_done;  // last word of run taken
        logic link_ok;   // current link valid and within walk bound
        logic cmp_last;  // compare index at last word
        logic cmp_miss;  // current word differs
        logic pool_full;
        logic store_last;
        logic out_busy;  // result register still occupied
    } t_stat;

    function automatic logic [31:0] hash_step(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] x;
        x = acc ^ w;
        return (x >> ROT_RIGHT) | (x << ROT_LEFT);
    endfunction

endpackage

// ===== rtl/backtrace_intern_table_top.sv =====
// ----------------------------------------------------------------------------
// backtrace_intern_table_top
// Interns fixed-depth backtraces in a chained hash store.
// ----------------------------------------------------------------------------
// Feed address words on s_axis; every backtrace_depth words close a run and
// produce one word on m_axis: tdata[9:0] context id, tuser[1:0] outcome.
// Input is taken one word a cycle while gathering; the closing word stalls
// input during lookup. Lookup reads the bucket head (head, head wait,
// check), compares each word (compare wait, compare) and follows each
// chain hop (link, link wait, check); a new entry writes MAX_DEPTH words,
// one per store step (one entry-word memory write port). The result
// register loads as the lookup ends and input resumes the cycle after the
// result word is taken.
// A stalled receiver holds the result and blocks all further input.
// Reset clears the pool count, sets depth to 4 and starts a clearing pass
// that empties one bucket head a cycle (all NUM_BUCKETS heads, 1024 by
// default) with s_axis_tready low. A cfg write drops a partial run.
// ----------------------------------------------------------------------------
module backtrace_intern_table_top #(
    parameter int NUM_BUCKETS = bit_pkg::NUM_BUCKETS_DEF,
    parameter int MAX_DEPTH   = bit_pkg::MAX_DEPTH_DEF,
    parameter int MAX_ENTRIES = bit_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] context_id, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] outcome
);
    bit_pkg::t_cmd  cmd;
    bit_pkg::t_stat stat;
    logic           rdy;
    logic [bit_pkg::ID_W-1:0] res_id;

    bit_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we,
        .i_stat(stat), .o_cmd(cmd), .o_in_ready(rdy)
    );

    bit_dp #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_DEPTH(MAX_DEPTH), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_word_valid(s_axis_tvalid && rdy),
        .i_word(s_axis_tdata),
        .i_cmd(cmd), .o_stat(stat),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_res_id(res_id), .o_res_outcome(m_axis_tuser)
    );

    assign s_axis_tready = rdy;
    assign m_axis_tdata  = {6'd0, res_id};
endmodule

// ===== rtl/bit_ctrl.sv =====
// ----------------------------------------------------------------------------
// bit_ctrl
// Sequencer of lookup, chain walk and store.
// ----------------------------------------------------------------------------
module bit_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  bit_pkg::t_stat  i_stat,
    output bit_pkg::t_cmd   o_cmd,
    output logic            o_in_ready
);
    bit_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bit_pkg::ST_CLEAR;
        end else if (i_cfg_we && r_state != bit_pkg::ST_CLEAR) begin
            r_state <= bit_pkg::ST_GATHER;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bit_pkg::ST_CLEAR:     if (i_stat.clr_last) n_state = bit_pkg::ST_GATHER;
            bit_pkg::ST_GATHER:    if (i_stat.run_done) n_state = bit_pkg::ST_HEAD;
            bit_pkg::ST_HEAD:      n_state = bit_pkg::ST_HEAD_WAIT;
            bit_pkg::ST_HEAD_WAIT: n_state = bit_pkg::ST_CHECK;
            bit_pkg::ST_CHECK: begin
                if (i_stat.link_ok)        n_state = bit_pkg::ST_CMP_WAIT;
                else if (i_stat.pool_full) n_state = bit_pkg::ST_OUT;
                else                       n_state = bit_pkg::ST_STORE;
            end
            bit_pkg::ST_CMP_WAIT:  n_state = bit_pkg::ST_CMP;
            bit_pkg::ST_CMP: begin
                if (i_stat.cmp_miss)      n_state = bit_pkg::ST_LINK;
                else if (i_stat.cmp_last) n_state = bit_pkg::ST_OUT;
                else                      n_state = bit_pkg::ST_CMP_WAIT;
            end
            bit_pkg::ST_LINK:      n_state = bit_pkg::ST_LINK_WAIT;
            bit_pkg::ST_LINK_WAIT: n_state = bit_pkg::ST_CHECK;
            bit_pkg::ST_STORE:     if (i_stat.store_last) n_state = bit_pkg::ST_OUT;
            bit_pkg::ST_OUT:       if (!i_stat.out_busy) n_state = bit_pkg::ST_GATHER;
            default:               n_state = bit_pkg::ST_GATHER;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bit_pkg::ST_CLEAR:  o_cmd.clr_step = 1'b1;
            bit_pkg::ST_GATHER: o_in_ready = 1'b1;
            bit_pkg::ST_HEAD:   o_cmd.head_rd = 1'b1;
            bit_pkg::ST_CHECK: begin
                if (i_stat.link_ok) o_cmd.cmp_start = 1'b1;
            end
            bit_pkg::ST_CMP: begin
                if (i_stat.cmp_miss) o_cmd.link_rd = 1'b1;
                else if (!i_stat.cmp_last) o_cmd.cmp_step = 1'b1;
                else o_cmd.res_found = 1'b1;
            end
            bit_pkg::ST_STORE: begin
                o_cmd.store_step = 1'b1;
                if (i_stat.store_last) begin
                    o_cmd.store_fin = 1'b1;
                    o_cmd.res_new   = 1'b1;
                end
            end
            default: ;
        endcase
        if (r_state == bit_pkg::ST_CHECK && !i_stat.link_ok && i_stat.pool_full)
            o_cmd.res_full = 1'b1;
    end

    // a run only closes from gather
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bit_pkg::ST_HEAD) |-> $past(r_state) == bit_pkg::ST_GATHER || $past(i_cfg_we)
            || $past(!i_rst_n))
        else $error("head read without closing word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == bit_pkg::ST_GATHER)
        else $error("ready outside gather");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.res_found, o_cmd.res_new, o_cmd.res_full}) <= 1)
        else $error("two results at once");
endmodule

// ===== rtl/bit_dp.sv =====
// ----------------------------------------------------------------------------
// bit_dp
// Gather, hash, chain memories, compare and result register.
// ----------------------------------------------------------------------------
module bit_dp #(
    parameter int NUM_BUCKETS = bit_pkg::NUM_BUCKETS_DEF,
    parameter int MAX_DEPTH   = bit_pkg::MAX_DEPTH_DEF,
    parameter int MAX_ENTRIES = bit_pkg::MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_data,
    input  logic                  i_word_valid,
    input  logic [31:0]           i_word,
    input  bit_pkg::t_cmd         i_cmd,
    output bit_pkg::t_stat        o_stat,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [bit_pkg::ID_W-1:0] o_res_id,
    output logic [1:0]            o_res_outcome
);
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = $clog2(MAX_DEPTH + 1);
    localparam int AW  = EW + DW;
    localparam int WW  = $clog2(MAX_DEPTH + 2);

    logic [4:0]      r_depth;
    logic [SW-1:0]   eff_depth;
    logic [WW-1:0]   r_seen;
    logic [31:0]     r_acc;
    logic [31:0]     r_gather [MAX_DEPTH];
    logic [BW-1:0]   r_bucket;
    logic [CW-1:0]   r_used;
    logic [BW-1:0]   r_clr_idx;
    logic [EW:0]     heads [NUM_BUCKETS];  // valid bit on top
    logic [EW:0]     links [MAX_ENTRIES];
    logic [31:0]     words [MAX_ENTRIES * MAX_DEPTH];
    logic [EW:0]     r_link;      // valid bit on top
    logic [EW:0]     r_head_q;
    logic [EW:0]     r_link_q;
    logic [31:0]     r_word_q;
    logic [SW-1:0]   r_ci;
    logic [CW-1:0]   r_steps;
    logic            r_sel_head;
    logic [31:0]     n_acc;
    logic [BW-1:0]   bucket_of;
    logic [EW:0]     cur_link;
    logic [bit_pkg::ID_W-1:0] id_ext;
    logic [AW-1:0]   waddr_rd_next;
    logic [EW-1:0]   lidx;

    always_comb begin
        if (r_depth == 5'd0) eff_depth = SW'(1);
        else if (32'(r_depth) > MAX_DEPTH) eff_depth = SW'(MAX_DEPTH);
        else eff_depth = SW'(r_depth);
    end

    assign n_acc     = bit_pkg::hash_step(r_acc, i_word);
    assign bucket_of = BW'(32'(n_acc) % NUM_BUCKETS);
    assign cur_link  = r_sel_head ? r_head_q : r_link_q;

    // gather and hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= bit_pkg::DEPTH_RESET;
            r_seen  <= '0;
            r_acc   <= '0;
        end else if (i_cfg_we) begin
            r_depth <= i_cfg_data;
            r_seen  <= '0;
            r_acc   <= '0;
        end else if (i_word_valid) begin
            if (32'(r_seen) + 1 >= 32'(eff_depth)) begin
                r_seen   <= '0;
                r_acc    <= '0;
            end else begin
                r_seen <= r_seen + WW'(1);
                r_acc  <= n_acc;
            end
            r_bucket <= bucket_of;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word_valid && 32'(r_seen) < MAX_DEPTH)
            r_gather[r_seen[DW-1:0]] <= i_word;
    end

    assign o_stat.run_done = i_word_valid && (32'(r_seen) + 1 >= 32'(eff_depth));

    // bucket heads: emptied one by one after reset, then one write per store
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) r_head_q <= heads[r_bucket];
        if (i_cmd.clr_step) heads[r_clr_idx] <= '0;
        else if (i_cmd.store_fin) heads[r_bucket] <= {1'b1, EW'(r_used)};
    end

    // the new entry links to the old head read at the start of the lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_rd) r_link_q <= links[r_link[EW-1:0]];
        if (i_cmd.store_fin) links[EW'(r_used)] <= r_head_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_start || i_cmd.cmp_step) r_word_q <= words[waddr_rd_next];
        if (i_cmd.store_step)
            words[{EW'(r_used), r_ci[DW-1:0]}] <= (r_ci < eff_depth) ? r_gather[r_ci[DW-1:0]]
                                                                     : 32'd0;
    end

    assign lidx = i_cmd.cmp_start ? cur_link[EW-1:0] : r_link[EW-1:0];
    assign waddr_rd_next = {lidx, i_cmd.cmp_start ? DW'(0) : DW'(r_ci + SW'(1))};

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_sel_head <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr_idx <= r_clr_idx + BW'(1);
            if (i_cmd.head_rd) begin
                r_sel_head <= 1'b1;
                r_steps    <= '0;
                r_ci       <= '0;
            end
            if (i_cmd.cmp_start) begin
                r_link <= cur_link;
                r_ci   <= '0;
            end
            if (i_cmd.cmp_step) r_ci <= r_ci + SW'(1);
            if (i_cmd.link_rd) begin
                r_sel_head <= 1'b0;
                r_steps    <= r_steps + CW'(1);
                r_ci       <= '0;
            end
            if (i_cmd.store_step) r_ci <= r_ci + SW'(1);
            if (i_cmd.store_fin) r_used <= r_used + CW'(1);
        end
    end

    assign o_stat.clr_last  = (32'(r_clr_idx) == NUM_BUCKETS - 1);
    assign o_stat.link_ok   = cur_link[EW] && (r_steps < r_used);
    assign o_stat.cmp_last  = (r_ci + SW'(1) >= eff_depth);
    assign o_stat.cmp_miss  = (r_word_q != r_gather[r_ci[DW-1:0]]);
    assign o_stat.pool_full = (32'(r_used) >= MAX_ENTRIES);
    assign o_stat.store_last = (32'(r_ci) + 1 >= MAX_DEPTH);
    assign o_stat.out_busy  = o_res_valid && !i_res_ready;

    assign id_ext = bit_pkg::ID_W'(32'(r_link[EW-1:0]));

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.res_found || i_cmd.res_new || i_cmd.res_full) begin
            o_res_valid <= 1'b1;
        end else if (o_res_valid && i_res_ready) begin
            o_res_valid <= 1'b0;
        end
        if (i_cmd.res_found) begin
            o_res_id <= id_ext; o_res_outcome <= bit_pkg::OUT_FOUND;
        end
        if (i_cmd.res_new) begin
            o_res_id <= bit_pkg::ID_W'(32'(r_used)); o_res_outcome <= bit_pkg::OUT_NEW;
        end
        if (i_cmd.res_full) begin
            o_res_id <= '0; o_res_outcome <= bit_pkg::OUT_FULL;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_fin |-> !o_stat.pool_full)
        else $error("store into full pool");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_new |=> o_res_valid && o_res_outcome == bit_pkg::OUT_NEW)
        else $error("new result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_found || i_cmd.res_new || i_cmd.res_full) |-> !o_res_valid || i_res_ready)
        else $error("result overwritten");
endmodule
